### design/stc_pkg.sv
// Package for the space-to-tab compressor: tab stop, character codes,
// sequencer states and the per-transaction plan struct.
// No dependencies; stc_plan and the top level import it.
package stc_pkg;

   localparam int TAB_STOP = 8;
   localparam int COL_W    = $clog2(TAB_STOP);
   localparam int CNT_W    = $clog2(TAB_STOP + 1);

   localparam logic [CNT_W-1:0] TAB_STOP_CNT = CNT_W'(TAB_STOP);

   localparam logic [7:0] CH_TEXT_CTRL_LO = 8'h08;
   localparam logic [7:0] CH_TEXT_CTRL_HI = 8'h0D;
   localparam logic [7:0] CH_TEXT_LO      = 8'h20;
   localparam logic [7:0] CH_TEXT_HI      = 8'h7E;
   localparam logic [7:0] CH_TAB          = 8'h09;
   localparam logic [7:0] CH_NL           = 8'h0A;
   localparam logic [7:0] CH_SPACE        = 8'h20;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic             valid_char;   // at least one of the two bytes is text
      logic             emit;         // the transaction produces results
      logic [CNT_W-1:0] space_cnt;    // spaces sent ahead of the final byte
      logic [7:0]       final_char;
      logic [COL_W-1:0] col_next;
      logic [COL_W-1:0] pend_next;
   } plan_type;

endpackage

### design/stc_if.sv
// Stream interfaces for the request and response channels.
// Depends on nothing; carries valid/ready handshake plus payload.
interface stc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] next_char;
   logic [7:0] fallback_char;

   modport source (output valid, output next_char, output fallback_char, input ready);
   modport sink   (input valid, input next_char, input fallback_char, output ready);
endinterface

interface stc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface

### design/stc_plan.sv
// Decodes one request into a plan: how many spaces to send, the final
// byte, and the new column and pending counts. Depends on stc_pkg.
module stc_plan (
   input  logic [7:0]               next_char,
   input  logic [7:0]               fallback_char,
   input  logic [stc_pkg::COL_W-1:0] column,
   input  logic [stc_pkg::COL_W-1:0] pending,
   output stc_pkg::plan_type        plan
);
   import stc_pkg::*;

   function automatic logic is_text(input logic [7:0] c);
      is_text = (c >= CH_TEXT_CTRL_LO && c <= CH_TEXT_CTRL_HI) ||
                (c >= CH_TEXT_LO && c <= CH_TEXT_HI);
   endfunction

   logic [7:0]       sel_char;
   logic [CNT_W-1:0] sum;
   logic [CNT_W-1:0] sum_inc;
   logic             at_stop;

   // Column plus pending always stays below the tab stop, so one more
   // column can at most land exactly on the stop.
   assign sum     = CNT_W'(column) + CNT_W'(pending);
   assign sum_inc = sum + CNT_W'(1);
   assign at_stop = (sum_inc == TAB_STOP_CNT);

   always_comb begin
      plan.valid_char = 1'b1;
      if (is_text(next_char)) begin
         sel_char = next_char;
      end else if (is_text(fallback_char)) begin
         sel_char = fallback_char;
      end else begin
         sel_char        = next_char;
         plan.valid_char = 1'b0;
      end

      plan.emit       = plan.valid_char;
      plan.space_cnt  = '0;
      plan.final_char = sel_char;
      plan.col_next   = '0;
      plan.pend_next  = '0;

      if (!plan.valid_char) begin
         plan.col_next  = column;
         plan.pend_next = pending;
      end else if (sel_char == CH_SPACE) begin
         if (at_stop) begin
            plan.final_char = CH_TAB;
         end else begin
            plan.emit      = 1'b0;
            plan.col_next  = column;
            plan.pend_next = pending + COL_W'(1);
         end
      end else if (sel_char == CH_NL) begin
         plan.final_char = CH_NL;
      end else if (sel_char == CH_TAB) begin
         plan.space_cnt  = TAB_STOP_CNT - sum;
         plan.final_char = CH_TAB;
      end else begin
         plan.space_cnt = CNT_W'(pending);
         plan.col_next  = at_stop ? '0 : sum_inc[COL_W-1:0];
      end
   end

endmodule

### design/space_to_tab_compress_stream.sv
// Top level of the space-to-tab compressor: sequencer, counters and the
// response register. Depends on stc_pkg, stc_if and stc_plan.
//
//   Channel   Direction  Payload                       Handshake
//   req_bus   in         next_char[7:0], fallback_char  valid/ready
//   rsp_bus   out        out_char[7:0], last            valid/ready
//
// A request is taken while idle; its results then go out on the response side,
// spaces first and final byte last, and no new request is taken until the last is accepted.
// The down counter that meters the spaces of a run is the shared unit.
// Requests that produce no result (held spaces, no text) leave the sequencer idle.
// Reset is synchronous and clears the column, pending count, space counter and sequencer.
// Ready is high only while idle; a stalled response simply holds.
module space_to_tab_compress_stream (
   input logic clock,
   input logic reset,
   stc_req_if.sink   req_bus,
   stc_rsp_if.source rsp_bus
);
   import stc_pkg::*;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       final_ff, final_in;

   plan_type plan;
   logic     req_fire;
   logic     rsp_fire;

   stc_plan u_plan (
      .next_char     (req_bus.next_char),
      .fallback_char (req_bus.fallback_char),
      .column        (col_ff),
      .pending       (pend_ff),
      .plan          (plan)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && plan.emit) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_fire && cnt_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_bus.ready    = 1'b0;
      rsp_bus.valid    = 1'b0;
      rsp_bus.out_char = (cnt_ff != '0) ? CH_SPACE : final_ff;
      rsp_bus.last     = (cnt_ff == '0);
      col_in           = col_ff;
      pend_in          = pend_ff;
      cnt_in           = cnt_ff;
      final_in         = final_ff;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire) begin
               col_in   = plan.col_next;
               pend_in  = plan.pend_next;
               cnt_in   = plan.space_cnt;
               final_in = plan.final_char;
            end
         end
         ST_SEND: begin
            rsp_bus.valid = 1'b1;
            if (rsp_fire && cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         pend_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff <= final_in;
   end

   // A response never overlaps acceptance of a new request.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_bus.valid && req_bus.ready))
      else $error("response valid while request ready");

   // Held spaces plus column never reach the tab stop.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(col_ff) + CNT_W'(pend_ff)) < TAB_STOP_CNT)
      else $error("pending spaces overrun the tab stop");

   // A space taken mid-run keeps the sequencer sending.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_bus.last) |=> rsp_bus.valid)
      else $error("space run cut short");

   // Taking the last result returns the block to ready.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_bus.last) |=> req_bus.ready)
      else $error("not ready after final result");

   // A run of spaces never exceeds the tab stop.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= TAB_STOP_CNT)
      else $error("space count out of range");

endmodule
